### design/bfifo_pkg.sv
`timescale 1ns / 1ps
package bfifo_pkg;

	localparam int DEPTH     = 1024;
	localparam int MAX_BURST = 64;

	localparam int AW = $clog2(DEPTH);
	localparam int LW = AW + 1;
	localparam int CW = 7;
	localparam int BW = 8;

	localparam logic [2:0] ACT_PUSH  = 3'd0;
	localparam logic [2:0] ACT_POP   = 3'd1;
	localparam logic [2:0] ACT_PEEK  = 3'd2;
	localparam logic [2:0] ACT_DROP  = 3'd3;
	localparam logic [2:0] ACT_FLUSH = 3'd4;

	localparam logic [1:0] K_SINGLE = 2'd0;
	localparam logic [1:0] K_PUSH   = 2'd1;
	localparam logic [1:0] K_BURST  = 2'd2;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	typedef struct packed {
		logic          status;
		logic [LW-1:0] fill;
		logic [LW-1:0] free;
		logic          empty;
		logic          full;
	} stat_t;

	typedef struct packed {
		logic [1:0]    kind;
		logic [BW-1:0] data;
		logic [AW-1:0] addr;
		logic [CW-1:0] cnt;
		stat_t         stat;
	} cmd_t;

	// index plus offset, wrapped once by the capacity
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] idx,
			input logic [LW-1:0] off, input logic [LW-1:0] cap);
		logic [LW:0] s;
		s = {2'b00, idx} + {1'b0, off};
		if (s >= {1'b0, cap})
			s = s - {1'b0, cap};
		return s[AW-1:0];
	endfunction

endpackage

### design/bfifo_front.sv
`timescale 1ns / 1ps
module bfifo_front import bfifo_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [LW-1:0] cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    action,
	input  logic [BW-1:0] push_byte,
	input  logic [CW-1:0] count,
	input  logic [LW-1:0] peek_offset,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output cmd_t          cmd,
	output logic [LW-1:0] cap
);

	logic [AW-1:0] wr_q, rd_q;
	logic [LW-1:0] held_q, cap_q;
	logic [AW-1:0] wr_n, rd_n;
	logic [LW-1:0] held_n, off, cfg_sat, cnt_w, avail;
	logic          reject, accept;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;
	assign cap       = cap_q;
	assign cnt_w     = {{(LW-CW){1'b0}}, count};

	always_comb begin
		wr_n     = wr_q;
		rd_n     = rd_q;
		held_n   = held_q;
		reject   = 1'b0;
		off      = (action == ACT_PEEK) ? peek_offset : '0;
		avail    = held_q - off;
		cmd.kind = K_SINGLE;
		cmd.data = push_byte;
		cmd.addr = wr_q;
		cmd.cnt  = count;
		if (action > ACT_FLUSH ||
				(action != ACT_PUSH && action != ACT_FLUSH && cnt_w > LW'(MAX_BURST))) begin
			reject = 1'b1;
		end else begin
			unique case (action) inside
				ACT_PUSH: begin
					if (held_q >= cap_q) begin
						reject = 1'b1;
					end else begin
						cmd.kind = K_PUSH;
						wr_n     = wrap_add(wr_q, LW'(1), cap_q);
						held_n   = held_q + LW'(1);
					end
				end
				ACT_POP, ACT_PEEK: begin
					if (off > held_q || cnt_w > avail) begin
						reject = 1'b1;
					end else if (count != '0) begin
						cmd.kind = K_BURST;
						cmd.addr = wrap_add(rd_q, off, cap_q);
						if (action == ACT_POP) begin
							rd_n   = wrap_add(rd_q, cnt_w, cap_q);
							held_n = held_q - cnt_w;
						end
					end
				end
				ACT_DROP: begin
					if (cnt_w > held_q) begin
						reject = 1'b1;
					end else begin
						rd_n   = wrap_add(rd_q, cnt_w, cap_q);
						held_n = held_q - cnt_w;
					end
				end
				default: begin
					wr_n   = '0;
					rd_n   = '0;
					held_n = '0;
				end
			endcase
		end
		if (reject) begin
			cmd.kind = K_SINGLE;
			wr_n     = wr_q;
			rd_n     = rd_q;
			held_n   = held_q;
		end
		cmd.stat.status = reject ? ST_ERR : ST_OK;
		cmd.stat.fill   = held_n;
		cmd.stat.free   = cap_q - held_n;
		cmd.stat.empty  = (held_n == '0);
		cmd.stat.full   = (held_n == cap_q);
	end

	always_comb begin
		if (cfg_wdata == '0)
			cfg_sat = LW'(1);
		else if (cfg_wdata > LW'(DEPTH))
			cfg_sat = LW'(DEPTH);
		else
			cfg_sat = cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			held_q <= '0;
			cap_q  <= LW'(DEPTH);
		end else if (cfg_we) begin
			wr_q   <= '0;
			rd_q   <= '0;
			held_q <= '0;
			cap_q  <= cfg_sat;
		end else if (accept) begin
			wr_q   <= wr_n;
			rd_q   <= rd_n;
			held_q <= held_n;
		end
	end

endmodule

### design/bfifo_cmdq.sv
`timescale 1ns / 1ps
module bfifo_cmdq import bfifo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t       ent_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       do_wr, do_rd;

	assign in_ready  = (cnt_q != 3'd4);
	assign out_valid = (cnt_q != 3'd0);
	assign out_cmd   = ent_q[rp_q];
	assign do_wr     = in_valid && in_ready;
	assign do_rd     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 2'd1;
			if (do_rd)
				rp_q <= rp_q + 2'd1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 3'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule

### design/bfifo_back.sv
`timescale 1ns / 1ps
module bfifo_back import bfifo_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [LW-1:0] cap,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  cmd_t          cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [BW-1:0] out_byte,
	output logic          byte_valid,
	output logic          last,
	output stat_t         out_stat
);

	logic [BW-1:0] mem [DEPTH];
	logic [BW-1:0] rdata_q;

	logic          busy_q;
	cmd_t          cur_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] remain_q;

	logic          valid_s1, bvalid_s1, last_s1;
	stat_t         stat_s1;
	logic          valid_s2, bvalid_s2, last_s2;
	logic [BW-1:0] byte_s2;
	stat_t         stat_s2;

	logic          adv_s2, issue_ok, issue, take, i_rd, i_wr, i_last;
	logic [AW-1:0] i_addr;
	stat_t         i_stat;

	assign adv_s2   = !valid_s2 || out_ready;
	assign issue_ok = !valid_s1 || adv_s2;

	always_comb begin
		issue  = 1'b0;
		take   = 1'b0;
		i_rd   = 1'b0;
		i_wr   = 1'b0;
		i_last = 1'b1;
		i_addr = cmd.addr;
		i_stat = busy_q ? cur_q.stat : cmd.stat;
		if (issue_ok) begin
			if (busy_q) begin
				issue  = 1'b1;
				i_rd   = 1'b1;
				i_addr = addr_q;
				i_last = (remain_q == CW'(1));
			end else if (cmd_valid) begin
				issue = 1'b1;
				take  = 1'b1;
				if (cmd.kind == K_BURST) begin
					i_rd   = 1'b1;
					i_last = (cmd.cnt == CW'(1));
				end else begin
					i_wr = (cmd.kind == K_PUSH);
				end
			end
		end
	end

	assign cmd_ready = take;

	// the read data register changes only when a read is issued
	always_ff @(posedge clk) begin
		if (i_wr)
			mem[i_addr] <= cmd.data;
		if (i_rd)
			rdata_q <= mem[i_addr];
	end

	always_ff @(posedge clk) begin
		if (take && cmd.kind == K_BURST)
			cur_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			addr_q   <= '0;
			remain_q <= '0;
		end else if (busy_q && issue) begin
			addr_q   <= wrap_add(addr_q, LW'(1), cap);
			remain_q <= remain_q - CW'(1);
			if (remain_q == CW'(1))
				busy_q <= 1'b0;
		end else if (take && cmd.kind == K_BURST && cmd.cnt != CW'(1)) begin
			busy_q   <= 1'b1;
			addr_q   <= wrap_add(cmd.addr, LW'(1), cap);
			remain_q <= cmd.cnt - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			bvalid_s1 <= i_rd;
			last_s1   <= i_last;
			stat_s1   <= i_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			bvalid_s2 <= bvalid_s1;
			last_s2   <= last_s1;
			stat_s2   <= stat_s1;
			byte_s2   <= bvalid_s1 ? rdata_q : '0;
		end
	end

	assign out_valid  = valid_s2;
	assign out_byte   = byte_s2;
	assign byte_valid = bvalid_s2;
	assign last       = last_s2;
	assign out_stat   = stat_s2;

endmodule

### design/byte_ring_fifo_with_peek.sv
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tuser action, tdata push_byte/count/peek_offset
// m_axis    out  tvalid/tready         tuser byte_valid, tlast last, tdata byte and status
// cfg       in   cfg_we                cfg_wdata capacity
//
// the front takes one item per cycle while the 4-entry command queue has room
// pop/peek of count>0: one result per byte, one per cycle off the read port unless stalled
// every other item gives one result, through the command queue then registers s1 and s2
// reset zeroes indices, fill count and queues, cap = DEPTH; ring stays unset until written
// a stall on m_axis backs up through the queue to s_axis without losing items
module byte_ring_fifo_with_peek import bfifo_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [LW-1:0] cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// push_byte[7:0], count[14:8], peek_offset[25:15], zero[31:26]
	input  logic [31:0]   s_axis_tdata,
	// action[2:0]
	input  logic [2:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// out_byte[7:0], status[8], fill_level[19:9], free_slots[30:20], is_empty[31],
	// is_full[32], zero[39:33]
	output logic [39:0]   m_axis_tdata,
	// byte_valid[0]
	output logic          m_axis_tuser,
	output logic          m_axis_tlast
);

	logic          f_valid, f_ready, q_valid, q_ready;
	cmd_t          f_cmd, q_cmd;
	logic [LW-1:0] cap;
	logic [BW-1:0] out_byte;
	stat_t         out_stat;

	bfifo_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.action      (s_axis_tuser),
		.push_byte   (s_axis_tdata[7:0]),
		.count       (s_axis_tdata[14:8]),
		.peek_offset (s_axis_tdata[25:15]),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd         (f_cmd),
		.cap         (cap)
	);

	bfifo_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	bfifo_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.cmd        (q_cmd),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (out_byte),
		.byte_valid (m_axis_tuser),
		.last       (m_axis_tlast),
		.out_stat   (out_stat)
	);

	assign m_axis_tdata = {7'd0, out_stat.full, out_stat.empty, out_stat.free,
		out_stat.fill, out_stat.status, out_byte};

endmodule
